// File: sv/weighted_vertex_skinning_top_assert.svh
// Assertion macros for the skinning engine checker.
`ifndef WEIGHTED_VERTEX_SKINNING_TOP_ASSERT_SVH
`define WEIGHTED_VERTEX_SKINNING_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define WVS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define WVS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// File: sv/wvs_pkg.sv
// Shared types and constants for the skinning engine.
package wvs_pkg;
	localparam int MaxJointsDefault = 64;
	localparam int IdxW = 6;

	typedef enum logic [0:0] {
		CMD_LOAD  = 1'b0,
		CMD_WEIGHT = 1'b1
	} cmd_t;

	typedef struct packed {
		logic                     command;
		logic [IdxW-1:0]          joint_index;
		logic [15:0]              bias;
		logic signed [31:0]       vec_x;
		logic signed [31:0]       vec_y;
		logic signed [31:0]       vec_z;
		logic signed [15:0]       aux_x;
		logic signed [15:0]       aux_y;
		logic signed [15:0]       aux_z;
		logic signed [15:0]       quat_w;
		logic                     last_weight;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] nrm_x;
		logic signed [15:0] nrm_y;
		logic signed [15:0] nrm_z;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_U1,
		ST_U2,
		ST_T1,
		ST_T2,
		ST_R,
		ST_BIAS,
		ST_ACC,
		ST_EMIT
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic capture;
		logic load;
		logic read;
		logic u1;
		logic u2;
		logic t1;
		logic t2;
		logic r;
		logic bias;
		logic acc;
		logic emit;
	} cmd_bus_t;

	typedef struct packed {
		logic is_weight;
		logic is_last;
		logic out_busy;
	} sts_bus_t;

	function automatic logic signed [47:0] sat48(input logic signed [49:0] x);
		if (x > 50'sh0_7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
		if (x < -50'sh0_8000_0000_0000) return 48'sh8000_0000_0000;
		return x[47:0];
	endfunction

	function automatic logic signed [31:0] sat32w(input logic signed [47:0] x);
		if (x > 48'sh0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
		if (x < -48'sh0000_8000_0000) return 32'sh8000_0000;
		return x[31:0];
	endfunction

	function automatic logic signed [31:0] sat32n(input logic signed [33:0] x);
		if (x > 34'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
		if (x < -34'sh0_8000_0000) return 32'sh8000_0000;
		return x[31:0];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [31:0] x);
		if (x > 32'sh0000_7FFF) return 16'sh7FFF;
		if (x < -32'sh0000_8000) return 16'sh8000;
		return x[15:0];
	endfunction
endpackage

// File: sv/wvs_if.sv
// Valid/ready channel interfaces for input and result beats.
interface wvs_in_if import wvs_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface wvs_out_if import wvs_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: sv/wvs_ctrl.sv
// Sequencer that steps one item through the skinning datapath.
module wvs_ctrl import wvs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  sts_bus_t sts,
	output cmd_bus_t cmd
);
	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_nxt;
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_nxt = ST_READ;
			ST_READ: state_nxt = sts.is_weight ? ST_U1 : ST_IDLE;
			ST_U1:   state_nxt = ST_U2;
			ST_U2:   state_nxt = ST_T1;
			ST_T1:   state_nxt = ST_T2;
			ST_T2:   state_nxt = ST_R;
			ST_R:    state_nxt = ST_BIAS;
			ST_BIAS: state_nxt = ST_ACC;
			ST_ACC:  state_nxt = sts.is_last ? ST_EMIT : ST_IDLE;
			// hold until the result register is free
			ST_EMIT: if (!sts.out_busy) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.capture = in_valid;
			end
			ST_READ: begin
				cmd.load = !sts.is_weight;
				cmd.read = sts.is_weight;
			end
			ST_U1:   cmd.u1 = 1'b1;
			ST_U2:   cmd.u2 = 1'b1;
			ST_T1:   cmd.t1 = 1'b1;
			ST_T2:   cmd.t2 = 1'b1;
			ST_R:    cmd.r = 1'b1;
			ST_BIAS: cmd.bias = 1'b1;
			ST_ACC:  cmd.acc = 1'b1;
			ST_EMIT: cmd.emit = !sts.out_busy;
			default: cmd = '0;
		endcase
	end
endmodule

// File: sv/wvs_dp.sv
// Joint table, rotation arithmetic, accumulators and result register.
module wvs_dp import wvs_pkg::*; #(
	parameter int MAX_JOINTS = MaxJointsDefault
) (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  in_data,
	input  cmd_bus_t  cmd,
	output sts_bus_t  sts,
	input  logic      out_ready,
	output logic      out_valid,
	output out_item_t out_data
);
	localparam int AW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;

	// entry layout: pos x, y, z (32 each), then quaternion w, x, y, z (16 each)
	logic [159:0] jtab [MAX_JOINTS];
	in_item_t     it_q;
	logic         hit_q;
	logic signed [31:0] jp_q [3];
	logic signed [15:0] q_q [4];
	// v is the vector being rotated; position and normal are rotated side by side in separate registers
	logic signed [49:0] pu_q [3], nu_q [3];
	logic signed [49:0] pt_q [3], nt_q [3];
	logic signed [49:0] pr_q [3], nr_q [3];
	logic signed [49:0] pb_q [3], nb_q [3];
	logic signed [47:0] psum_q [3];
	logic signed [31:0] nsum_q [3];
	logic               ov_q;
	out_item_t          od_q;

	logic signed [49:0] pv [3], nv [3];
	logic [AW-1:0] widx;
	logic          inrange;

	assign inrange = ({3'b0, it_q.joint_index} < 9'(MAX_JOINTS));
	assign widx = AW'(it_q.joint_index);
	assign pv[0] = 50'(it_q.vec_x); assign pv[1] = 50'(it_q.vec_y);
	assign pv[2] = 50'(it_q.vec_z);
	assign nv[0] = 50'(it_q.aux_x); assign nv[1] = 50'(it_q.aux_y);
	assign nv[2] = 50'(it_q.aux_z);

	assign sts.is_weight = (it_q.command == CMD_WEIGHT);
	assign sts.is_last = it_q.last_weight;
	assign sts.out_busy = ov_q && !out_ready;

	function automatic logic signed [49:0] rsh(input logic signed [69:0] p, input int s);
		logic signed [69:0] a;
		a = p + (70'sd1 <<< (s - 1));
		return 50'(a >>> s);
	endfunction

	// cross product term a*b - c*d, full width and unrounded
	function automatic logic signed [69:0] xp(input logic signed [15:0] a,
		input logic signed [49:0] b, input logic signed [15:0] c,
		input logic signed [49:0] d);
		return 70'(a * b) - 70'(c * d);
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.capture) it_q <= in_data;
		if (cmd.load && inrange)
			jtab[widx] <= {it_q.vec_x, it_q.vec_y, it_q.vec_z,
				it_q.quat_w, it_q.aux_x, it_q.aux_y, it_q.aux_z};
		if (cmd.read) begin
			hit_q <= inrange;
			{jp_q[0], jp_q[1], jp_q[2], q_q[0], q_q[1], q_q[2], q_q[3]} <= jtab[widx];
		end
		if (cmd.u1) begin
			// zero quaternion and position for an index past the table
			if (!hit_q) begin
				for (int i = 0; i < 3; i++) jp_q[i] <= '0;
				for (int i = 0; i < 4; i++) q_q[i] <= '0;
			end
		end
		if (cmd.u2) begin
			pu_q[0] <= rsh(xp(q_q[2], pv[2], q_q[3], pv[1]), 14);
			pu_q[1] <= rsh(xp(q_q[3], pv[0], q_q[1], pv[2]), 14);
			pu_q[2] <= rsh(xp(q_q[1], pv[1], q_q[2], pv[0]), 14);
			nu_q[0] <= rsh(xp(q_q[2], nv[2], q_q[3], nv[1]), 14);
			nu_q[1] <= rsh(xp(q_q[3], nv[0], q_q[1], nv[2]), 14);
			nu_q[2] <= rsh(xp(q_q[1], nv[1], q_q[2], nv[0]), 14);
		end
		if (cmd.t1) begin
			pt_q[0] <= 50'(xp(q_q[2], pu_q[2], q_q[3], pu_q[1]));
			pt_q[1] <= 50'(xp(q_q[3], pu_q[0], q_q[1], pu_q[2]));
			pt_q[2] <= 50'(xp(q_q[1], pu_q[1], q_q[2], pu_q[0]));
			nt_q[0] <= 50'(xp(q_q[2], nu_q[2], q_q[3], nu_q[1]));
			nt_q[1] <= 50'(xp(q_q[3], nu_q[0], q_q[1], nu_q[2]));
			nt_q[2] <= 50'(xp(q_q[1], nu_q[1], q_q[2], nu_q[0]));
		end
		if (cmd.t2) begin
			for (int i = 0; i < 3; i++) begin
				pr_q[i] <= pv[i] + rsh(70'(pt_q[i] + 50'(q_q[0] * pu_q[i])) <<< 1, 14);
				nr_q[i] <= nv[i] + rsh(70'(nt_q[i] + 50'(q_q[0] * nu_q[i])) <<< 1, 14);
			end
		end
		if (cmd.r) begin
			for (int i = 0; i < 3; i++) pr_q[i] <= pr_q[i] + 50'(jp_q[i]);
		end
		if (cmd.bias) begin
			for (int i = 0; i < 3; i++) begin
				pb_q[i] <= rsh(70'(pr_q[i]) * $signed({1'b0, it_q.bias}), 15);
				nb_q[i] <= rsh(70'(nr_q[i]) * $signed({1'b0, it_q.bias}), 15);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				psum_q[i] <= '0;
				nsum_q[i] <= '0;
			end
			ov_q <= 1'b0;
		end else begin
			if (cmd.acc) begin
				for (int i = 0; i < 3; i++) begin
					psum_q[i] <= sat48(50'(psum_q[i]) + pb_q[i]);
					nsum_q[i] <= sat32n(34'(nsum_q[i]) + 34'(sat32n(34'(nb_q[i]))) +
						34'(nb_q[i] - 50'(sat32n(34'(nb_q[i])))));
				end
			end
			if (cmd.emit) begin
				for (int i = 0; i < 3; i++) begin
					psum_q[i] <= '0;
					nsum_q[i] <= '0;
				end
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			od_q.pos_x <= sat32w(psum_q[0]);
			od_q.pos_y <= sat32w(psum_q[1]);
			od_q.pos_z <= sat32w(psum_q[2]);
			od_q.nrm_x <= sat16(nsum_q[0]);
			od_q.nrm_y <= sat16(nsum_q[1]);
			od_q.nrm_z <= sat16(nsum_q[2]);
		end
	end

	assign out_valid = ov_q;
	assign out_data = od_q;
endmodule

// File: sv/weighted_vertex_skinning_top.sv
// Top level of the quaternion linear blend skinning engine.
// channel | dir | beat contents
// in_ch   | in  | command, joint_index, bias, vec_x/y/z, aux_x/y/z, quat_w, last_weight
// out_ch  | out | pos_x/y/z, nrm_x/y/z
// A joint load passes idle and read; a weight goes on through u1, u2, t1, t2, r, bias and acc,
// and a last weight adds emit, all on one shared rotate/bias datapath stepped by the sequencer.
// arst_n clears the sums, the sequencer and the result valid; the joint table is not cleared.
// A full result register stalls the sequencer in its emit step until out_ch takes the beat.
module weighted_vertex_skinning_top import wvs_pkg::*; #(
	parameter int MAX_JOINTS = MaxJointsDefault
) (
	input logic     clk,
	input logic     arst_n,
	wvs_in_if.sink  in_ch,
	wvs_out_if.source out_ch
);
	cmd_bus_t cmd;
	sts_bus_t sts;

	wvs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.sts(sts), .cmd(cmd)
	);

	wvs_dp #(.MAX_JOINTS(MAX_JOINTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_data(in_ch.data), .cmd(cmd), .sts(sts),
		.out_ready(out_ch.ready), .out_valid(out_ch.valid), .out_data(out_ch.data)
	);
endmodule

// File: sv/wvs_checker.sv
// Port-level checker for the skinning engine, bound to the top level.
`include "weighted_vertex_skinning_top_assert.svh"
module wvs_checker import wvs_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);
	`WVS_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result beat dropped or changed")
	`WVS_ASSERT_NXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready, "second beat taken while busy")
	`WVS_ASSERT_IMP(a_no_out_reset, clk, arst_n, $rose(arst_n), !out_valid, "result valid out of reset")
endmodule

bind weighted_vertex_skinning_top wvs_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
